// ===== design/kfsi_pkg.sv =====
// Package for the keyframe spline interpolator: keyframe record type, codes,
// sequencer states and default sizes. No dependencies.
`default_nettype none
package kfsi_pkg;

  localparam int MAX_KEYS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_W         = 40;
  localparam int ENTRY_W       = 7;
  localparam int VAL_W         = 32;

  typedef enum logic [1:0] {
    ACT_EVAL   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_STEP    = 2'd1,
    MODE_CATMULL = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WRITE,
    S_DIV,
    S_FETCH,
    S_COEF,
    S_MUL,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0]        ktime;
    logic [1:0]         kmode;
    logic signed [31:0] kx;
    logic signed [31:0] ky;
    logic signed [31:0] kz;
    logic signed [31:0] kw;
  } key_rec_t;

  typedef struct packed {
    logic load;
    logic step;
  } mac_ctrl_t;

endpackage
`default_nettype wire

// ===== design/keyframe_spline_interpolator_top.sv =====
// Top level of the keyframe spline interpolator: sorted keyframe memory,
// sequencer, segment divider and the shared multiply-accumulate unit.
// Depends on kfsi_pkg and kfsi_mac.
// Clear and unused actions, a rejected insert and an empty evaluate go straight to done.
// Insert scans memory for the key's place, shifts the later records up by one and
// then writes the new key.
// Evaluate scans memory, divides for the fraction inside a segment at one quotient bit
// per cycle, reads four records, then works out each component, on the MAC unless held.
// One item at a time; results come as a one-cycle done_o beat and cannot stall.
// Reset empties the table; the memory contents are not cleared.
`default_nettype none
module keyframe_spline_interpolator_top import kfsi_pkg::*; #(
  parameter int MAX_KEYS  = MAX_KEYS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start,
  output logic                    busy,
  input  wire logic [1:0]         action_i,
  input  wire logic [31:0]        event_time_i,
  input  wire logic [1:0]         interp_mode_i,
  input  wire logic signed [31:0] in_x_i,
  input  wire logic signed [31:0] in_y_i,
  input  wire logic signed [31:0] in_z_i,
  input  wire logic signed [31:0] in_w_i,
  output logic                    done_o,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  output logic signed [31:0]      out_w_o,
  output logic [ENTRY_W-1:0]      entry_count_o,
  output logic                    insert_rejected_o,
  output logic                    table_empty_o
);

  localparam int IDX_W = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int IT_W  = $clog2(FRAC_BITS);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-32){1'b1}}, 32'h80000000};

  state_e state_q, state_d;

  key_rec_t key_mem_q [MAX_KEYS];
  key_rec_t rd_q;
  key_rec_t new_rec_q, new_rec_d;
  key_rec_t pts_q [4];
  key_rec_t pts_d [4];

  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             wr_en;
  key_rec_t         wr_data;

  logic [1:0]           act_q, act_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic [CNT_W-1:0]     seg_q, seg_d;
  logic                 vld_q, vld_d;
  logic                 first_le_q, first_le_d;
  logic                 hold_q, hold_d;
  logic [31:0]          last_t_q, last_t_d;
  logic [31:0]          rem_q, rem_d;
  logic [31:0]          dv_q, dv_d;
  logic [FRAC_BITS-1:0] quo_q, quo_d;
  logic [IT_W-1:0]      it_q, it_d;
  logic [2:0]           fc_q, fc_d;
  logic [1:0]           comp_q, comp_d;
  logic [1:0]           step_q, step_d;
  logic                 lin_q, lin_d;
  logic signed [ACC_W-1:0] c2_q, c2_d, c1_q, c1_d, c0_q, c0_d;
  logic signed [31:0]   res_q [4];
  logic signed [31:0]   res_d [4];
  logic                 rej_q, rej_d, emp_q, emp_d, done_q, done_d;

  logic                 accept, rec_hit, scan_end, first_le_now, div_last, mul_last;
  logic                 use_hold;
  logic [CNT_W-1:0]     k_idx, seg_prev, seg_next1, seg_next2;
  logic [32:0]          r2;
  logic                 r2_ge;
  logic signed [ACC_W-1:0] pa, pb, pc, pd, cr3, cr2, cr1, cr0, fin_val, mac_init, mac_add;
  logic signed [ACC_W-1:0] mac_acc;
  mac_ctrl_t            mac_ctrl;

  function automatic logic signed [31:0] comp_of(key_rec_t r, logic [1:0] c);
    logic signed [31:0] v;
    unique case (c)
      2'd0:    v = r.kx;
      2'd1:    v = r.ky;
      2'd2:    v = r.kz;
      default: v = r.kw;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] v);
    logic signed [31:0] s;
    if (v > SAT_HI) begin
      s = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      s = 32'sh80000000;
    end else begin
      s = v[31:0];
    end
    return s;
  endfunction

  assign accept       = start && !busy;
  assign rec_hit      = vld_q && (rd_q.ktime > new_rec_q.ktime);
  assign scan_end     = rec_hit || (ptr_q == count_q);
  assign k_idx        = rec_hit ? ptr_q - CNT_W'(1) : count_q;
  assign first_le_now = (vld_q && ptr_q == CNT_W'(1)) ? (new_rec_q.ktime <= rd_q.ktime)
                                                      : first_le_q;
  assign div_last     = it_q == IT_W'(FRAC_BITS - 1);
  assign mul_last     = lin_q || step_q == 2'd2;
  assign use_hold     = hold_q || pts_q[1].kmode == MODE_STEP;
  assign seg_prev     = (seg_q == '0) ? seg_q : seg_q - CNT_W'(1);
  assign seg_next1    = seg_q + CNT_W'(1);
  assign seg_next2    = (({1'b0, seg_q} + (CNT_W+1)'(2)) < {1'b0, count_q})
                        ? seg_q + CNT_W'(2) : seg_q + CNT_W'(1);
  assign r2           = {rem_q, 1'b0};
  assign r2_ge        = r2 >= {1'b0, dv_q};

  assign pa  = ACC_W'(comp_of(pts_q[0], comp_q));
  assign pb  = ACC_W'(comp_of(pts_q[1], comp_q));
  assign pc  = ACC_W'(comp_of(pts_q[2], comp_q));
  assign pd  = ACC_W'(comp_of(pts_q[3], comp_q));
  assign cr3 = pd - pa + ((pb - pc) <<< 1) + (pb - pc);
  assign cr2 = (pa <<< 1) - (pb <<< 2) - pb + (pc <<< 2) - pd;
  assign cr1 = pc - pa;
  assign cr0 = pb <<< 1;
  assign fin_val = lin_q ? mac_acc : (mac_acc >>> 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (action_i == ACT_EVAL && count_q != '0) begin
            state_d = S_SCAN;
          end else if (action_i == ACT_INSERT && count_q != CNT_W'(MAX_KEYS)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          priority if (act_q == ACT_INSERT) begin
            state_d = S_SHIFT_RD;
          end else if (first_le_now || count_q == CNT_W'(1) || !rec_hit) begin
            state_d = S_FETCH;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_SHIFT_RD:  state_d = (ptr_q == seg_q) ? S_INS_WRITE : S_SHIFT_WR;
      S_SHIFT_WR:  state_d = S_SHIFT_RD;
      S_INS_WRITE: state_d = S_DONE;
      S_DIV:       state_d = div_last ? S_FETCH : S_DIV;
      S_FETCH:     state_d = (fc_q == 3'd4) ? S_COEF : S_FETCH;
      S_COEF: begin
        if (use_hold) begin
          state_d = (comp_q == 2'd3) ? S_DONE : S_COEF;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL:       state_d = mul_last ? S_FIN : S_MUL;
      S_FIN:       state_d = (comp_q == 2'd3) ? S_DONE : S_COEF;
      S_DONE:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    act_d      = act_q;
    new_rec_d  = new_rec_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    seg_d      = seg_q;
    vld_d      = vld_q;
    first_le_d = first_le_q;
    hold_d     = hold_q;
    last_t_d   = last_t_q;
    rem_d      = rem_q;
    dv_d       = dv_q;
    quo_d      = quo_q;
    it_d       = it_q;
    fc_d       = fc_q;
    comp_d     = comp_q;
    step_d     = step_q;
    lin_d      = lin_q;
    c2_d       = c2_q;
    c1_d       = c1_q;
    c0_d       = c0_q;
    pts_d      = pts_q;
    res_d      = res_q;
    rej_d      = rej_q;
    emp_d      = emp_q;
    done_d     = 1'b0;
    rd_addr    = ptr_q[IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = ptr_q[IDX_W-1:0];
    wr_data    = rd_q;
    mac_ctrl   = '0;
    mac_init   = cr3;
    mac_add    = c0_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d           = action_i;
          new_rec_d.ktime = event_time_i;
          new_rec_d.kmode = interp_mode_i;
          new_rec_d.kx    = in_x_i;
          new_rec_d.ky    = in_y_i;
          new_rec_d.kz    = in_z_i;
          new_rec_d.kw    = in_w_i;
          ptr_d           = '0;
          vld_d           = 1'b0;
          first_le_d      = 1'b0;
          for (int c = 0; c < 4; c++) begin
            res_d[c] = '0;
          end
          rej_d = (action_i == ACT_INSERT) && (count_q == CNT_W'(MAX_KEYS));
          emp_d = (action_i == ACT_EVAL) && (count_q == '0);
          if (action_i == ACT_CLEAR) begin
            count_d = '0;
          end
        end
      end
      S_SCAN: begin
        if (vld_q && ptr_q == CNT_W'(1)) begin
          first_le_d = first_le_now;
        end
        if (scan_end) begin
          if (act_q == ACT_INSERT) begin
            seg_d = k_idx;
            ptr_d = count_q;
          end else begin
            fc_d = '0;
            priority if (first_le_now || count_q == CNT_W'(1)) begin
              seg_d  = '0;
              hold_d = 1'b1;
            end else if (!rec_hit) begin
              seg_d  = count_q - CNT_W'(1);
              hold_d = 1'b1;
            end else begin
              seg_d  = k_idx - CNT_W'(1);
              hold_d = 1'b0;
              rem_d  = new_rec_q.ktime - last_t_q;
              dv_d   = rd_q.ktime - last_t_q;
              it_d   = '0;
            end
          end
        end else begin
          if (vld_q) begin
            last_t_d = rd_q.ktime;
          end
          ptr_d = ptr_q + CNT_W'(1);
          vld_d = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        rd_addr = IDX_W'(ptr_q - CNT_W'(1));
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_q[IDX_W-1:0];
        wr_data = rd_q;
        ptr_d   = ptr_q - CNT_W'(1);
      end
      S_INS_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = seg_q[IDX_W-1:0];
        wr_data = new_rec_q;
        count_d = count_q + CNT_W'(1);
      end
      S_DIV: begin
        rem_d = r2_ge ? 32'(r2 - {1'b0, dv_q}) : r2[31:0];
        quo_d = {quo_q[FRAC_BITS-2:0], r2_ge};
        it_d  = it_q + IT_W'(1);
      end
      S_FETCH: begin
        unique case (fc_q)
          3'd0:    rd_addr = seg_prev[IDX_W-1:0];
          3'd1:    rd_addr = seg_q[IDX_W-1:0];
          3'd2:    rd_addr = seg_next1[IDX_W-1:0];
          default: rd_addr = seg_next2[IDX_W-1:0];
        endcase
        if (fc_q != 3'd0) begin
          pts_d[fc_q[1:0] - 2'd1] = rd_q;
        end
        fc_d   = fc_q + 3'd1;
        comp_d = '0;
      end
      S_COEF: begin
        step_d = '0;
        if (use_hold) begin
          res_d[comp_q] = pb[31:0];
          comp_d        = comp_q + 2'd1;
        end else if (pts_q[1].kmode == MODE_LINEAR) begin
          mac_ctrl.load = 1'b1;
          mac_init      = pc - pb;
          c0_d          = pb;
          lin_d         = 1'b1;
        end else begin
          mac_ctrl.load = 1'b1;
          mac_init      = cr3;
          c2_d          = cr2;
          c1_d          = cr1;
          c0_d          = cr0;
          lin_d         = 1'b0;
        end
      end
      S_MUL: begin
        mac_ctrl.step = 1'b1;
        priority if (lin_q || step_q == 2'd2) begin
          mac_add = c0_q;
        end else if (step_q == 2'd0) begin
          mac_add = c2_q;
        end else begin
          mac_add = c1_q;
        end
        step_d = step_q + 2'd1;
      end
      S_FIN: begin
        res_d[comp_q] = sat32(fin_val);
        comp_d        = comp_q + 2'd1;
      end
      S_DONE: begin
        done_d = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  kfsi_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .init_i   (mac_init),
    .frac_i   (quo_q),
    .addend_i (mac_add),
    .acc_o    (mac_acc)
  );

  always_ff @(posedge clk_i) begin
    rd_q <= key_mem_q[rd_addr];
    if (wr_en) begin
      key_mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    new_rec_q  <= new_rec_d;
    ptr_q      <= ptr_d;
    seg_q      <= seg_d;
    vld_q      <= vld_d;
    first_le_q <= first_le_d;
    hold_q     <= hold_d;
    last_t_q   <= last_t_d;
    rem_q      <= rem_d;
    dv_q       <= dv_d;
    quo_q      <= quo_d;
    it_q       <= it_d;
    fc_q       <= fc_d;
    comp_q     <= comp_d;
    step_q     <= step_d;
    lin_q      <= lin_d;
    c2_q       <= c2_d;
    c1_q       <= c1_d;
    c0_q       <= c0_d;
    pts_q      <= pts_d;
    res_q      <= res_d;
    rej_q      <= rej_d;
    emp_q      <= emp_d;
  end

  assign busy              = state_q != S_IDLE;
  assign done_o            = done_q;
  assign out_x_o           = res_q[0];
  assign out_y_o           = res_q[1];
  assign out_z_o           = res_q[2];
  assign out_w_o           = res_q[3];
  assign entry_count_o     = ENTRY_W'(count_q);
  assign insert_rejected_o = rej_q;
  assign table_empty_o     = emp_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result beat while the sequencer is still busy");

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_KEYS)) else $error("keyframe count exceeds the table size");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted item did not start the sequencer");

  a_reject_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && insert_rejected_o) |-> (count_q == CNT_W'(MAX_KEYS)))
    else $error("insert rejected with room in the table");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_empty_o) |-> (out_x_o == 0 && out_w_o == 0 && count_q == '0))
    else $error("empty-table result carries data");

endmodule
`default_nettype wire

// ===== design/kfsi_mac.sv =====
// Shared multiply-accumulate unit: acc <= floor(acc * frac / 2^FRAC_BITS) + addend.
// Depends on kfsi_pkg.
`default_nettype none
module kfsi_mac import kfsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire mac_ctrl_t                   ctrl_i,
  input  wire logic signed [ACC_W-1:0]     init_i,
  input  wire logic        [FRAC_BITS-1:0] frac_i,
  input  wire logic signed [ACC_W-1:0]     addend_i,
  output logic signed      [ACC_W-1:0]     acc_o
);

  localparam int PW = ACC_W + FRAC_BITS + 1;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    shifted;

  always_comb begin
    prod    = acc_q * $signed({1'b0, frac_i});
    shifted = prod >>> FRAC_BITS;
    if (ctrl_i.load) begin
      acc_d = init_i;
    end else if (ctrl_i.step) begin
      acc_d = $signed(shifted[ACC_W-1:0]) + addend_i;
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_keyframe_spline_interpolator_top.sv =====
// Self-checking testbench for keyframe_spline_interpolator_top: drives insert,
// evaluate and clear beats and compares each done_o beat with a local predictor.
// Depends on kfsi_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_keyframe_spline_interpolator_top import kfsi_pkg::*;;

  localparam int NKEYS = MAX_KEYS_DEF;
  localparam int FB    = FRAC_BITS_DEF;

  typedef struct {
    logic signed [31:0] ox, oy, oz, ow;
    logic [ENTRY_W-1:0] cnt;
    logic               rej;
    logic               empty;
  } frame_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         action_i = ACT_EVAL;
  logic [31:0]        event_time_i = '0;
  logic [1:0]         interp_mode_i = MODE_LINEAR;
  logic signed [31:0] in_x_i = '0, in_y_i = '0, in_z_i = '0, in_w_i = '0;
  logic               done_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o, out_w_o;
  logic [ENTRY_W-1:0] entry_count_o;
  logic               insert_rejected_o, table_empty_o;

  logic [31:0]        kt [NKEYS];
  logic [1:0]         km [NKEYS];
  logic signed [31:0] kv [4][NKEYS];
  int                 nkeys = 0;
  frame_res_t         pending_frames[$];
  int                 mismatches = 0;
  int                 stray_beats = 0;
  int                 idle_pct = 0;

  keyframe_spline_interpolator_top u_dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .event_time_i, .interp_mode_i,
    .in_x_i, .in_y_i, .in_z_i, .in_w_i, .done_o, .out_x_o, .out_y_o, .out_z_o,
    .out_w_o, .entry_count_o, .insert_rejected_o, .table_empty_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] spline_comp(longint p0, longint p1, longint p2,
                                                     longint p3, longint f);
    longint acc;
    acc = -p0 + 3 * p1 - 3 * p2 + p3;
    acc = ((acc * f) >>> FB) + (2 * p0 - 5 * p1 + 4 * p2 - p3);
    acc = ((acc * f) >>> FB) + (p2 - p0);
    acc = ((acc * f) >>> FB) + 2 * p1;
    return sat32(acc >>> 1);
  endfunction

  function automatic void interpolate(logic [31:0] q, ref frame_res_t r);
    int i, pv, nx, c;
    longint f;
    logic [63:0] num, den;
    if (q <= kt[0] || nkeys == 1) begin
      i = 0;
    end else if (q >= kt[nkeys-1]) begin
      i = nkeys - 1;
    end else begin
      i = 0;
      while (i + 2 < nkeys && !(kt[i] <= q && kt[i+1] > q)) i++;
      pv = (i > 0) ? i - 1 : i;
      nx = (i + 2 < nkeys) ? i + 2 : i + 1;
      num = {32'd0, q - kt[i]} << FB;
      den = {32'd0, kt[i+1] - kt[i]};
      f = longint'(num / den);
      for (c = 0; c < 4; c++) begin
        if (km[i] == MODE_LINEAR) begin
          r.ox = sat32(longint'(kv[c][i]) +
                       (((longint'(kv[c][i+1]) - longint'(kv[c][i])) * f) >>> FB));
        end else if (km[i] == MODE_STEP) begin
          r.ox = kv[c][i];
        end else begin
          r.ox = spline_comp(kv[c][pv], kv[c][i], kv[c][i+1], kv[c][nx], f);
        end
        case (c)
          1: r.oy = r.ox;
          2: r.oz = r.ox;
          3: r.ow = r.ox;
          default: ;
        endcase
        if (c == 0) r.ow = r.ox;
      end
      r.ox = r.ow;
      for (c = 0; c < 4; c++) begin
        if (km[i] == MODE_LINEAR)
          r.ow = sat32(longint'(kv[c][i]) +
                       (((longint'(kv[c][i+1]) - longint'(kv[c][i])) * f) >>> FB));
        else if (km[i] == MODE_STEP)
          r.ow = kv[c][i];
        else
          r.ow = spline_comp(kv[c][pv], kv[c][i], kv[c][i+1], kv[c][nx], f);
        case (c)
          0: r.ox = r.ow;
          1: r.oy = r.ow;
          2: r.oz = r.ow;
          default: ;
        endcase
      end
      return;
    end
    r.ox = kv[0][i]; r.oy = kv[1][i]; r.oz = kv[2][i]; r.ow = kv[3][i];
  endfunction

  function automatic void predict_frame(logic [1:0] act, logic [31:0] t, logic [1:0] md,
                                        logic signed [31:0] x, logic signed [31:0] y,
                                        logic signed [31:0] z, logic signed [31:0] w);
    frame_res_t r;
    int pos, j;
    r = '{ox: 0, oy: 0, oz: 0, ow: 0, cnt: 0, rej: 0, empty: 0};
    if (act == ACT_EVAL) begin
      if (nkeys == 0) r.empty = 1'b1;
      else interpolate(t, r);
    end else if (act == ACT_INSERT) begin
      if (nkeys >= NKEYS) begin
        r.rej = 1'b1;
      end else begin
        pos = 0;
        while (pos < nkeys && kt[pos] <= t) pos++;
        for (j = nkeys; j > pos; j--) begin
          kt[j] = kt[j-1]; km[j] = km[j-1];
          kv[0][j] = kv[0][j-1]; kv[1][j] = kv[1][j-1];
          kv[2][j] = kv[2][j-1]; kv[3][j] = kv[3][j-1];
        end
        kt[pos] = t; km[pos] = md;
        kv[0][pos] = x; kv[1][pos] = y; kv[2][pos] = z; kv[3][pos] = w;
        nkeys++;
      end
    end else if (act == ACT_CLEAR) begin
      nkeys = 0;
    end
    r.cnt = nkeys[ENTRY_W-1:0];
    pending_frames.push_back(r);
  endfunction

  always @(posedge clk_i) begin
    frame_res_t e;
    if (done_o) begin
      if (pending_frames.size() == 0) begin
        stray_beats++;
        if (mismatches + stray_beats <= 10) $display("Unexpected result beat at %0t", $realtime);
      end else begin
        e = pending_frames.pop_front();
        if (out_x_o !== e.ox || out_y_o !== e.oy || out_z_o !== e.oz || out_w_o !== e.ow ||
            entry_count_o !== e.cnt || insert_rejected_o !== e.rej ||
            table_empty_o !== e.empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp %h %h %h %h cnt %0d rej %b emp %b, got %h %h %h %h cnt %0d rej %b emp %b",
                     e.ox, e.oy, e.oz, e.ow, e.cnt, e.rej, e.empty, out_x_o, out_y_o,
                     out_z_o, out_w_o, entry_count_o, insert_rejected_o, table_empty_o);
        end
      end
    end
  end

  task automatic send_beat(logic [1:0] act, logic [31:0] t, logic [1:0] md,
                           logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic signed [31:0] w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act; event_time_i <= t; interp_mode_i <= md;
    in_x_i <= x; in_y_i <= y; in_z_i <= z; in_w_i <= w;
    do @(posedge clk_i); while (busy);
    predict_frame(act, t, md, x, y, z, w);
  endtask

  task automatic drain_results();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (pending_frames.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(3))
      0: return $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    if ($urandom_range(3) == 0) return $urandom;
    if (nkeys > 0 && $urandom_range(4) == 0) return kt[$urandom_range(nkeys - 1)];
    return $urandom_range(255) << 12;
  endfunction

  task automatic test_empty_table();
    send_beat(ACT_EVAL, 32'd0, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_EVAL, 32'hffffffff, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(2'd3, 32'h1234, MODE_STEP, 1, 2, 3, 4);
    send_beat(ACT_CLEAR, 32'd0, MODE_LINEAR, 0, 0, 0, 0);
  endtask

  task automatic test_segment_modes();
    send_beat(ACT_INSERT, 32'h0001_0000, MODE_LINEAR, 32'sh7fffffff, 32'sh80000000, 0, 5);
    send_beat(ACT_EVAL, 32'd0, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_EVAL, 32'h0005_0000, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_INSERT, 32'h0003_0000, MODE_STEP, 32'sh80000000, 32'sh7fffffff, -7, 9);
    send_beat(ACT_INSERT, 32'h0005_0000, MODE_CATMULL, 32'sh7fffffff, 32'sh80000000, 1, -1);
    send_beat(ACT_INSERT, 32'h0007_0000, 2'd3, 32'sh80000000, 32'sh7fffffff, 99, 3);
    send_beat(ACT_INSERT, 32'hffffffff, MODE_LINEAR, 32'sh1000, -32'sh1000, 0, 0);
    send_beat(ACT_INSERT, 32'h0003_0000, MODE_LINEAR, 42, 43, 44, 45);
    send_beat(ACT_EVAL, 32'h0002_0000, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_EVAL, 32'h0003_8000, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_EVAL, 32'h0004_0001, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_EVAL, 32'h0006_c000, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_EVAL, 32'h0008_0000, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_EVAL, 32'hffffffff, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_EVAL, 32'h0001_0000, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_CLEAR, 32'd0, MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_EVAL, 32'h0001_0000, MODE_LINEAR, 0, 0, 0, 0);
  endtask

  task automatic test_full_table();
    for (int k = 0; k < NKEYS + 2; k++)
      send_beat(ACT_INSERT, $urandom_range(63) << 10, $urandom_range(3),
                rand_val(), rand_val(), rand_val(), rand_val());
    for (int k = 0; k < 4; k++)
      send_beat(ACT_EVAL, $urandom_range(65535), MODE_LINEAR, 0, 0, 0, 0);
    send_beat(ACT_CLEAR, 32'd0, MODE_LINEAR, 0, 0, 0, 0);
  endtask

  task automatic test_random_beats(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 45)
        send_beat(ACT_INSERT, rand_time(), $urandom_range(3),
                  rand_val(), rand_val(), rand_val(), rand_val());
      else if (r < 92)
        send_beat(ACT_EVAL, rand_time(), $urandom_range(3), $urandom, $urandom,
                  $urandom, $urandom);
      else if (r < 97)
        send_beat(ACT_CLEAR, $urandom, $urandom_range(3), $urandom, 0, 0, 0);
      else
        send_beat(2'd3, $urandom, $urandom_range(3), $urandom, 0, 0, 0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_segment_modes();
    test_full_table();
    drain_results();
    idle_pct = 0;
    test_random_beats(190);
    idle_pct = 81;
    test_random_beats(190);
    drain_results();
    idle_pct = 7;
    test_random_beats(190);
    idle_pct = 0;
    test_random_beats(190);
    drain_results();
    if (mismatches == 0 && stray_beats == 0 && pending_frames.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
